FILE: rtl/pip_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pip_pkg
// Shared types and constants of the point-in-polygon crossing test.
// ----------------------------------------------------------------------------
package pip_pkg;

	// request codes on req_type
	localparam logic REQ_WRITE = 1'b0;
	localparam logic REQ_TEST  = 1'b1;

	// smallest polygon the block will walk
	localparam int unsigned MIN_VERTICES = 3;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_PRIME,
		ST_WALK,
		ST_DRAIN
	} ctrl_state_t;

	// controller to datapath
	typedef struct packed {
		logic wr_en;
		logic start;
		logic rd_en;
		logic first;
		logic load_res;
	} pip_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic busy;
		logic res_full;
	} pip_sts_t;

endpackage

FILE: rtl/point_in_polygon_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// point_in_polygon_test
// Even-odd crossing test of a point against a stored polygon.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready): req_type selects a vertex write, which
// stores coord_x/coord_y at vertex_index, or a point test of coord_x/coord_y.
// Output channel (out_valid/out_ready): one inside_res per point test, none
// per write. cfg_we/cfg_wdata set vertex_count (used as 3..MAX_VERTICES).
// A vertex write does not leave the idle state. A point test reads the
// vertex store once per vertex through its single read port, plus the
// closing vertex first, and feeds a three-stage edge pipeline: the result
// is loaded once that pipeline is empty, which depends on whether the last
// edges straddle the point, and the next transaction is taken the
// cycle after the result is loaded.
// If the receiver stalls, the result waits in the output register while the
// next transaction is taken; a following test holds its own result until
// the register frees up. Reset empties the output, returns the sequencer to
// idle and sets vertex_count to 3; the vertex store is not cleared, and a
// test must only use vertices that were written.
// ----------------------------------------------------------------------------
module point_in_polygon_test #(
	parameter int unsigned MAX_VERTICES = 64,
	parameter int unsigned COORD_BITS   = 24
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic                                  req_type,
	input  logic [$clog2(MAX_VERTICES)-1:0]       vertex_index,
	input  logic signed [COORD_BITS-1:0]          coord_x,
	input  logic signed [COORD_BITS-1:0]          coord_y,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic                                  inside_res,
	input  logic                                  cfg_we,
	input  logic [$clog2(MAX_VERTICES+1)-1:0]     cfg_wdata
);

	localparam int unsigned IDX_BITS = $clog2(MAX_VERTICES);
	localparam int unsigned CNT_BITS = $clog2(MAX_VERTICES + 1);

	pip_pkg::pip_cmd_t   cmd;
	pip_pkg::pip_sts_t   sts;
	logic [IDX_BITS-1:0] rd_addr;

	pip_ctrl #(
		.MAX_VERTICES (MAX_VERTICES),
		.IDX_BITS     (IDX_BITS),
		.CNT_BITS     (CNT_BITS)
	) u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.req_type     (req_type),
		.vertex_index (vertex_index),
		.out_ready    (out_ready),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.sts          (sts),
		.cmd          (cmd),
		.rd_addr      (rd_addr)
	);

	pip_datapath #(
		.MAX_VERTICES (MAX_VERTICES),
		.COORD_BITS   (COORD_BITS),
		.IDX_BITS     (IDX_BITS)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.rd_addr      (rd_addr),
		.vertex_index (vertex_index),
		.coord_x      (coord_x),
		.coord_y      (coord_y),
		.out_ready    (out_ready),
		.out_valid    (out_valid),
		.inside_res   (inside_res)
	);

endmodule

FILE: rtl/pip_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pip_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module pip_ram #(
	parameter int unsigned WIDTH = 24,
	parameter int unsigned DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

FILE: rtl/pip_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pip_ctrl
// Sequencer: takes transactions, holds the vertex count and walks the
// vertex store once per query, then hands the result to the output register.
// ----------------------------------------------------------------------------
module pip_ctrl #(
	parameter int unsigned MAX_VERTICES = 64,
	parameter int unsigned IDX_BITS     = 6,
	parameter int unsigned CNT_BITS     = 7
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic                  req_type,
	input  logic [IDX_BITS-1:0]   vertex_index,
	input  logic                  out_ready,
	input  logic                  cfg_we,
	input  logic [CNT_BITS-1:0]   cfg_wdata,
	input  pip_pkg::pip_sts_t     sts,
	output pip_pkg::pip_cmd_t     cmd,
	output logic [IDX_BITS-1:0]   rd_addr
);

	localparam logic [CNT_BITS-1:0] CNT_MIN = CNT_BITS'(pip_pkg::MIN_VERTICES);
	localparam logic [CNT_BITS-1:0] CNT_MAX = CNT_BITS'(MAX_VERTICES);

	pip_pkg::ctrl_state_t state_q, state_d;
	logic [CNT_BITS-1:0] count_q;
	logic [IDX_BITS-1:0] n_last_q;
	logic [IDX_BITS-1:0] addr_q;
	logic [CNT_BITS-1:0] count_clamped;
	logic                accept;
	logic                idx_ok;
	logic                res_go;

	always_comb begin
		if (count_q < CNT_MIN) begin
			count_clamped = CNT_MIN;
		end else if (count_q > CNT_MAX) begin
			count_clamped = CNT_MAX;
		end else begin
			count_clamped = count_q;
		end
	end

	assign idx_ok = ({1'b0, vertex_index} < (IDX_BITS + 1)'(MAX_VERTICES));
	assign res_go = !sts.busy && (!sts.res_full || out_ready);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			pip_pkg::ST_IDLE: begin
				if (in_valid && req_type == pip_pkg::REQ_TEST) begin
					state_d = pip_pkg::ST_PRIME;
				end
			end
			pip_pkg::ST_PRIME: begin
				state_d = pip_pkg::ST_WALK;
			end
			pip_pkg::ST_WALK: begin
				if (addr_q == n_last_q) begin
					state_d = pip_pkg::ST_DRAIN;
				end
			end
			pip_pkg::ST_DRAIN: begin
				if (res_go) begin
					state_d = pip_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = pip_pkg::ST_IDLE;
			end
		endcase
	end

	// outputs
	always_comb begin
		in_ready     = 1'b0;
		cmd          = '0;
		rd_addr      = addr_q;
		case (state_q)
			pip_pkg::ST_IDLE: begin
				in_ready = 1'b1;
			end
			pip_pkg::ST_PRIME: begin
				// fetch the closing vertex first, it is the start of edge zero
				cmd.rd_en = 1'b1;
				cmd.first = 1'b1;
				rd_addr   = n_last_q;
			end
			pip_pkg::ST_WALK: begin
				cmd.rd_en = 1'b1;
			end
			pip_pkg::ST_DRAIN: begin
				cmd.load_res = res_go;
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
		accept    = in_valid && in_ready;
		cmd.wr_en = accept && req_type == pip_pkg::REQ_WRITE && idx_ok;
		cmd.start = accept && req_type == pip_pkg::REQ_TEST;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= pip_pkg::ST_IDLE;
			count_q  <= CNT_MIN;
			n_last_q <= '0;
			addr_q   <= '0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				count_q <= cfg_wdata;
			end
			if (cmd.start) begin
				n_last_q <= IDX_BITS'(count_clamped - CNT_BITS'(1));
				addr_q   <= '0;
			end else if (state_q == pip_pkg::ST_WALK) begin
				addr_q <= addr_q + IDX_BITS'(1);
			end
		end
	end

`ifndef ASSERT_OFF
	a_rd_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.rd_en |-> (rd_addr <= n_last_q))
		else $error("vertex read beyond polygon");

	a_walk_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == pip_pkg::ST_WALK && addr_q == n_last_q) |=> state_q == pip_pkg::ST_DRAIN)
		else $error("walk did not stop at last vertex");

	a_start_primes: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.start |=> (state_q == pip_pkg::ST_PRIME && addr_q == '0))
		else $error("query start did not prime the walk");
`endif

endmodule

FILE: rtl/pip_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pip_datapath
// Vertex stores, three-stage edge pipeline (straddle and differences,
// cross products, compare and toggle) and the result register.
// ----------------------------------------------------------------------------
module pip_datapath #(
	parameter int unsigned MAX_VERTICES = 64,
	parameter int unsigned COORD_BITS   = 24,
	parameter int unsigned IDX_BITS     = 6
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  pip_pkg::pip_cmd_t            cmd,
	output pip_pkg::pip_sts_t            sts,
	input  logic [IDX_BITS-1:0]          rd_addr,
	input  logic [IDX_BITS-1:0]          vertex_index,
	input  logic signed [COORD_BITS-1:0] coord_x,
	input  logic signed [COORD_BITS-1:0] coord_y,
	input  logic                         out_ready,
	output logic                         out_valid,
	output logic                         inside_res
);

	localparam int unsigned DW = COORD_BITS + 1;
	localparam int unsigned PW = 2 * DW;

	logic [COORD_BITS-1:0]        x_rd, y_rd;
	logic signed [COORD_BITS-1:0] xi, yi;
	logic signed [COORD_BITS-1:0] px_q, py_q, xj_q, yj_q;
	logic                         rd_valid_q, rd_first_q;

	logic                         straddle;
	logic signed [DW-1:0]         a1_d, a2_d, b1_d, b2_d;
	logic signed [DW-1:0]         a1_s1, a2_s1, b1_s1, b2_s1;
	logic                         valid_s1, dy_pos_s1;
	logic signed [PW-1:0]         pa_s2, pb_s2;
	logic                         valid_s2, dy_pos_s2;
	logic                         left;
	logic                         inside_q;
	logic                         out_valid_q, inside_res_q;

	pip_ram #(.WIDTH(COORD_BITS), .DEPTH(MAX_VERTICES)) u_x_store (
		.clk   (clk),
		.we    (cmd.wr_en),
		.waddr (vertex_index),
		.wdata (coord_x),
		.re    (cmd.rd_en),
		.raddr (rd_addr),
		.rdata (x_rd)
	);

	pip_ram #(.WIDTH(COORD_BITS), .DEPTH(MAX_VERTICES)) u_y_store (
		.clk   (clk),
		.we    (cmd.wr_en),
		.waddr (vertex_index),
		.wdata (coord_y),
		.re    (cmd.rd_en),
		.raddr (rd_addr),
		.rdata (y_rd)
	);

	assign xi = x_rd;
	assign yi = y_rd;

	// edge runs from vertex j (previous) to vertex i (just read)
	assign straddle = (yi <= py_q && py_q < yj_q) || (yj_q <= py_q && py_q < yi);
	assign a1_d = {px_q[COORD_BITS-1], px_q} - {xi[COORD_BITS-1], xi};
	assign a2_d = {yj_q[COORD_BITS-1], yj_q} - {yi[COORD_BITS-1], yi};
	assign b1_d = {xj_q[COORD_BITS-1], xj_q} - {xi[COORD_BITS-1], xi};
	assign b2_d = {py_q[COORD_BITS-1], py_q} - {yi[COORD_BITS-1], yi};

	// edges with yj below yi (negative yj - yi) flip the sense of the cross-product compare
	assign left = dy_pos_s2 ? (pa_s2 < pb_s2) : (pa_s2 > pb_s2);

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			px_q <= coord_x;
			py_q <= coord_y;
		end
		if (rd_valid_q) begin
			xj_q <= xi;
			yj_q <= yi;
		end
		a1_s1     <= a1_d;
		a2_s1     <= a2_d;
		b1_s1     <= b1_d;
		b2_s1     <= b2_d;
		dy_pos_s1 <= !a2_d[DW-1];
		pa_s2     <= PW'(a1_s1) * PW'(a2_s1);
		pb_s2     <= PW'(b1_s1) * PW'(b2_s1);
		dy_pos_s2 <= dy_pos_s1;
		if (cmd.load_res) begin
			inside_res_q <= inside_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_valid_q  <= 1'b0;
			rd_first_q  <= 1'b0;
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			inside_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			rd_valid_q <= cmd.rd_en;
			rd_first_q <= cmd.first;
			valid_s1   <= rd_valid_q && !rd_first_q && straddle;
			valid_s2   <= valid_s1;
			if (cmd.start) begin
				inside_q <= 1'b0;
			end else if (valid_s2 && left) begin
				inside_q <= !inside_q;
			end
			if (cmd.load_res) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign sts.busy     = rd_valid_q || valid_s1 || valid_s2;
	assign sts.res_full = out_valid_q;
	assign out_valid    = out_valid_q;
	assign inside_res   = inside_res_q;

`ifndef ASSERT_OFF
	a_start_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.start |-> !sts.busy)
		else $error("query started while edge pipeline busy");

	a_load_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_res |-> (!sts.busy && (!out_valid_q || out_ready)))
		else $error("result loaded before pipeline drained or over pending result");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_ready) |=> (out_valid_q && $stable(inside_res_q)))
		else $error("pending result dropped or changed");
`endif

endmodule
